// File: hw/rtl/cbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbt_pkg;

  localparam int MAX_BINDINGS = 8;
  localparam int CNT_W        = $clog2(MAX_BINDINGS + 1);
  localparam int IDX_W        = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;

  localparam int CMD_W        = 2;
  localparam int PORT_W       = 8;
  localparam int CHAN_W       = 16;
  localparam int STATUS_W     = 3;
  localparam int COUNT_OUT_W  = 4;
  localparam int ENTRY_W      = CHAN_W + PORT_W;

  typedef enum logic [CMD_W-1:0] {
    OP_BIND   = 2'd0,
    OP_UNBIND = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_WRONG_TYPE = 3'd1,
    ST_TAKEN      = 3'd2,
    ST_FULL       = 3'd3,
    ST_NO_BINDING = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    ld_in;
    logic    idx_clr;
    logic    idx_inc;
    logic    wr_append;
    logic    wr_shift;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    sts_ld;
    status_t sts_code;
    logic    found_ld;
    logic    ld_out;
  } dp_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic streaming;
    logic at_end;
    logic full;
    logic hit;
    logic port_eq;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/channel_binding_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel binding table: up to MAX_BINDINGS (channel, port) pairs held in a
// compact, insertion-ordered list in a single-port-write, registered-read RAM.
// Requests are handled one at a time. Each passes through a decode/setup step,
// a scan that reads and then compares each table entry examined, and for an
// unbind a read and a write for each entry shifted down behind the removed one,
// before the result is handed to the output register. A clear or a rejected
// bind/unbind skips the scan. The registered RAM read is why each entry needs a
// separate read step and compare (or write) step. A finished result waits in
// the output register while the next request is taken.
module channel_binding_table (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [cbt_pkg::CMD_W-1:0]       in_command,
  input  wire logic [cbt_pkg::PORT_W-1:0]      in_port_index,
  input  wire logic [cbt_pkg::CHAN_W-1:0]      in_channel_number,
  input  wire logic                            in_is_streaming,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [cbt_pkg::STATUS_W-1:0]    out_status,
  output logic      [cbt_pkg::PORT_W-1:0]      out_found_port,
  output logic      [cbt_pkg::COUNT_OUT_W-1:0] out_entry_count
);

  import cbt_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  cbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  cbt_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .stat              (stat),
    .in_command        (in_command),
    .in_port_index     (in_port_index),
    .in_channel_number (in_channel_number),
    .in_is_streaming   (in_is_streaming),
    .out_status        (out_status),
    .out_found_port    (out_found_port),
    .out_entry_count   (out_entry_count)
  );

endmodule

`default_nettype wire

// File: hw/rtl/cbt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/cbt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cbt_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cbt_pkg::dp_ctrl_t              ctrl,
  output cbt_pkg::dp_stat_t                   stat,
  input  wire logic [cbt_pkg::CMD_W-1:0]      in_command,
  input  wire logic [cbt_pkg::PORT_W-1:0]     in_port_index,
  input  wire logic [cbt_pkg::CHAN_W-1:0]     in_channel_number,
  input  wire logic                           in_is_streaming,
  output logic      [cbt_pkg::STATUS_W-1:0]   out_status,
  output logic      [cbt_pkg::PORT_W-1:0]     out_found_port,
  output logic      [cbt_pkg::COUNT_OUT_W-1:0] out_entry_count
);

  import cbt_pkg::*;

  op_t                cmd_r;
  logic [PORT_W-1:0]  port_r;
  logic [CHAN_W-1:0]  chan_r;
  logic               strm_r;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   idx_m1;
  status_t            status_r, status_nxt;
  logic [PORT_W-1:0]  found_r, found_nxt;

  logic [STATUS_W-1:0]    out_status_r;
  logic [PORT_W-1:0]      out_found_r;
  logic [COUNT_OUT_W-1:0] out_count_r;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [CHAN_W-1:0]  rd_chan;
  logic [PORT_W-1:0]  rd_port;

  cbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BINDINGS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_chan = ram_rdata[ENTRY_W-1:PORT_W];
  assign rd_port = ram_rdata[PORT_W-1:0];
  assign idx_m1  = idx_r - CNT_W'(1);

  // append goes to the slot after the last entry; shift moves entry idx down by one
  assign ram_we    = ctrl.wr_append | ctrl.wr_shift;
  assign ram_waddr = ctrl.wr_append ? cnt_r[IDX_W-1:0] : idx_m1[IDX_W-1:0];
  assign ram_wdata = ctrl.wr_append ? {chan_r, port_r} : ram_rdata;

  always_comb begin
    idx_nxt = idx_r;
    if (ctrl.idx_clr) begin
      idx_nxt = '0;
    end else if (ctrl.idx_inc) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.cnt_clr) begin
      cnt_nxt = '0;
    end else if (ctrl.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctrl.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    status_nxt = status_r;
    found_nxt  = found_r;
    if (ctrl.ld_in) begin
      status_nxt = ST_OK;
      found_nxt  = '0;
    end else begin
      if (ctrl.sts_ld) begin
        status_nxt = ctrl.sts_code;
      end
      if (ctrl.found_ld) begin
        found_nxt = rd_port;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      cmd_r  <= op_t'(in_command);
      port_r <= in_port_index;
      chan_r <= in_channel_number;
      strm_r <= in_is_streaming;
    end
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    if (ctrl.ld_out) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_count_r  <= COUNT_OUT_W'(cnt_r);
    end
  end

  always_comb begin
    stat.op        = cmd_r;
    stat.streaming = strm_r;
    stat.at_end    = (idx_r == cnt_r);
    stat.full      = (cnt_r == CNT_W'(MAX_BINDINGS));
    stat.hit       = (cmd_r == OP_UNBIND) ? (rd_port == port_r) : (rd_chan == chan_r);
    stat.port_eq   = (rd_port == port_r);
  end

  assign out_status      = out_status_r;
  assign out_found_port  = out_found_r;
  assign out_entry_count = out_count_r;

endmodule

`default_nettype wire

// File: hw/rtl/cbt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cbt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire cbt_pkg::dp_stat_t stat,
  output cbt_pkg::dp_ctrl_t      ctrl
);

  import cbt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.op == OP_CLEAR) begin
          state_nxt = S_FINISH;
        end else if ((stat.op == OP_BIND || stat.op == OP_UNBIND) && !stat.streaming) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_nxt = stat.at_end ? S_FINISH : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (!stat.hit) begin
          state_nxt = S_SCAN_RD;
        end else if (stat.op == OP_UNBIND) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SHIFT_RD: begin
        state_nxt = stat.at_end ? S_FINISH : S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_nxt = S_SHIFT_RD;
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl     = '0;
    ctrl.sts_code = ST_OK;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.ld_in   = 1'b1;
          ctrl.idx_clr = 1'b1;
        end
      end
      S_DECODE: begin
        if (stat.op == OP_CLEAR) begin
          ctrl.cnt_clr = 1'b1;
        end else if ((stat.op == OP_BIND || stat.op == OP_UNBIND) && !stat.streaming) begin
          ctrl.sts_ld   = 1'b1;
          ctrl.sts_code = ST_WRONG_TYPE;
        end
      end
      S_SCAN_RD: begin
        // scan ran off the end without a match
        if (stat.at_end) begin
          case (stat.op)
            OP_BIND: begin
              if (stat.full) begin
                ctrl.sts_ld   = 1'b1;
                ctrl.sts_code = ST_FULL;
              end else begin
                ctrl.wr_append = 1'b1;
                ctrl.cnt_inc   = 1'b1;
              end
            end
            OP_LOOKUP: begin
              ctrl.sts_ld   = 1'b1;
              ctrl.sts_code = ST_NO_BINDING;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN_CMP: begin
        if (!stat.hit) begin
          ctrl.idx_inc = 1'b1;
        end else begin
          case (stat.op)
            OP_BIND: begin
              if (!stat.port_eq) begin
                ctrl.sts_ld   = 1'b1;
                ctrl.sts_code = ST_TAKEN;
              end
            end
            OP_LOOKUP: begin
              ctrl.found_ld = 1'b1;
            end
            OP_UNBIND: begin
              ctrl.idx_inc = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT_RD: begin
        if (stat.at_end) begin
          ctrl.cnt_dec = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        ctrl.wr_shift = 1'b1;
        ctrl.idx_inc  = 1'b1;
      end
      S_FINISH: begin
        ctrl.ld_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: hw/rtl/cbt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cbt_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [cbt_pkg::STATUS_W-1:0]    out_status,
  input wire logic [cbt_pkg::PORT_W-1:0]      out_found_port,
  input wire logic [cbt_pkg::COUNT_OUT_W-1:0] out_entry_count
);

  import cbt_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_found_port) && $stable(out_entry_count))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_found_port == '0)
    else $error("found port set on a failed request");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == COUNT_OUT_W'(MAX_BINDINGS))
    else $error("table full reported below capacity");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_WRONG_TYPE ||
      out_status == ST_TAKEN || out_status == ST_FULL || out_status == ST_NO_BINDING)
    else $error("undefined status code");

endmodule

bind channel_binding_table cbt_checker u_cbt_checker (.*);

`default_nettype wire
